// ===== src/sebc_pkg.sv =====
package sebc_pkg;

   localparam int FRAC_BITS = 8;
   localparam int CH_W = 8;
   localparam int SQ_W = 18;
   localparam int RAD_W = SQ_W + 2 * FRAC_BITS;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W = ROOT_W + 2;
   localparam int C1_W = ROOT_W + 1;
   localparam int C2_W = CH_W + 1 + FRAC_BITS;
   localparam int QUO_W = C1_W;
   localparam int NUM_W = QUO_W + CH_W;
   localparam int COST_W = 18;
   localparam logic [COST_W-1:0] COST_MAX = '1;
   localparam int WT_RESET = 0;
   localparam int MAX_RESET = 10;

   localparam logic REG_WEIGHT = 1'b0;
   localparam logic REG_MAX = 1'b1;

   typedef struct packed {
      logic [23:0] first_color_a;
      logic [23:0] first_color_b;
      logic [23:0] second_color_a;
      logic [23:0] second_color_b;
      logic [7:0]  first_grad_a;
      logic [7:0]  first_grad_b;
      logic [7:0]  second_grad_a;
      logic [7:0]  second_grad_b;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] seam_cost;
      logic              bad_setting;
   } rsp_type;

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [SQ_W-1:0] sq_dist(input logic [23:0] p, input logic [23:0] q);
      logic [SQ_W-1:0] sum;
      logic [CH_W-1:0] d;
      sum = '0;
      for (int ch = 0; ch < 3; ch++) begin
         d = abs_diff(p[ch*CH_W +: CH_W], q[ch*CH_W +: CH_W]);
         sum = sum + SQ_W'(d * d);
      end
      return sum;
   endfunction

endpackage

// ===== src/seam_edge_cost_blend.sv =====
// Throughput: one item per cycle; the pipeline keeps filling while the
// output waits, and bubbles close up under a stall.
// Stages: squared distances, 17 square root steps, blend, 18 division steps, output.
// Reset clears all valid bits and sets the registers to weight 0, max 10.
module seam_edge_cost_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sebc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sebc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import sebc_pkg::*;

   localparam int SQ_ST = 0;
   localparam int RT_FIRST = 1;
   localparam int B1_ST = RT_FIRST + ROOT_W;
   localparam int B2_ST = B1_ST + 1;
   localparam int B3_ST = B2_ST + 1;
   localparam int DV_FIRST = B3_ST + 1;
   localparam int OUT_ST = DV_FIRST + QUO_W;
   localparam int STAGES = OUT_ST + 1;

   logic [CH_W-1:0] weight_ff;
   logic [CH_W-1:0] max_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX) ? 32'(max_ff) : 32'(weight_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= CH_W'(WT_RESET);
         max_ff    <= CH_W'(MAX_RESET);
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_WEIGHT: weight_ff <= pwdata[CH_W-1:0];
            REG_MAX:    max_ff    <= pwdata[CH_W-1:0];
            default:    weight_ff <= weight_ff;
         endcase
      end
   end

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   logic [SQ_W-1:0] sq1_ff, sq2_ff;
   logic [C2_W-1:0] c2_ff [0:B1_ST-1];

   always_ff @(posedge clock) begin
      if (en[SQ_ST]) begin
         sq1_ff   <= sq_dist(req_data.first_color_a, req_data.first_color_b);
         sq2_ff   <= sq_dist(req_data.second_color_a, req_data.second_color_b);
         c2_ff[0] <= C2_W'({1'b0, abs_diff(req_data.first_grad_a, req_data.first_grad_b)}
                    + {1'b0, abs_diff(req_data.second_grad_a, req_data.second_grad_b)})
                    << FRAC_BITS;
      end
      for (int k = 1; k < B1_ST; k++) begin
         if (en[k]) begin
            c2_ff[k] <= c2_ff[k-1];
         end
      end
   end

   logic [RAD_W-1:0]  rad1 [0:ROOT_W], rad2 [0:ROOT_W];
   logic [REM_W-1:0]  rem1 [0:ROOT_W], rem2 [0:ROOT_W];
   logic [ROOT_W-1:0] root1 [0:ROOT_W], root2 [0:ROOT_W];

   assign rad1[0]  = {sq1_ff, {(2*FRAC_BITS){1'b0}}};
   assign rad2[0]  = {sq2_ff, {(2*FRAC_BITS){1'b0}}};
   assign rem1[0]  = '0;
   assign rem2[0]  = '0;
   assign root1[0] = '0;
   assign root2[0] = '0;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      sebc_sqrt_stage u_first (
         .clock(clock), .en(en[RT_FIRST + j]),
         .rad_in(rad1[j]), .rem_in(rem1[j]), .root_in(root1[j]),
         .rad_ff(rad1[j+1]), .rem_ff(rem1[j+1]), .root_ff(root1[j+1])
      );
      sebc_sqrt_stage u_second (
         .clock(clock), .en(en[RT_FIRST + j]),
         .rad_in(rad2[j]), .rem_in(rem2[j]), .root_in(root2[j]),
         .rad_ff(rad2[j+1]), .rem_ff(rem2[j+1]), .root_ff(root2[j+1])
      );
   end

   logic [C1_W-1:0]      c1_ff;
   logic [C2_W-1:0]      c2b_ff;
   logic [CH_W-1:0]      wt_ff, mw_ff;
   logic [CH_W+C1_W-1:0] p1_ff, p2_ff;
   logic [CH_W-1:0]      wt_clamp;
   logic [NUM_W:0]       num_sum;

   assign wt_clamp = (weight_ff > max_ff) ? max_ff : weight_ff;
   assign num_sum  = {1'b0, p1_ff} + {1'b0, p2_ff};

   logic [CH_W-1:0]  drem [0:QUO_W];
   logic [QUO_W-1:0] dacc [0:QUO_W];
   logic [CH_W-1:0]  drem0_ff;
   logic [QUO_W-1:0] dacc0_ff;

   always_ff @(posedge clock) begin
      if (en[B1_ST]) begin
         c1_ff  <= C1_W'({1'b0, root1[ROOT_W]} + {1'b0, root2[ROOT_W]});
         c2b_ff <= c2_ff[B1_ST-1];
         wt_ff  <= wt_clamp;
         mw_ff  <= max_ff - wt_clamp;
      end
      if (en[B2_ST]) begin
         p1_ff <= mw_ff * c1_ff;
         p2_ff <= (CH_W+C1_W)'(wt_ff * c2b_ff);
      end
      if (en[B3_ST]) begin
         drem0_ff <= num_sum[NUM_W-1:QUO_W];
         dacc0_ff <= num_sum[QUO_W-1:0];
      end
   end

   assign drem[0] = drem0_ff;
   assign dacc[0] = dacc0_ff;

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      sebc_div_stage u_step (
         .clock(clock), .en(en[DV_FIRST + j]), .divisor(max_ff),
         .rem_in(drem[j]), .acc_in(dacc[j]),
         .rem_ff(drem[j+1]), .acc_ff(dacc[j+1])
      );
   end

   logic [31:0] quo32;
   rsp_type     out_ff;

   assign quo32 = 32'(dacc[QUO_W]);

   always_ff @(posedge clock) begin
      if (en[OUT_ST]) begin
         if (max_ff == '0) begin
            out_ff.seam_cost   <= '0;
            out_ff.bad_setting <= 1'b1;
         end else begin
            out_ff.seam_cost   <= (quo32 > 32'(COST_MAX)) ? COST_MAX : quo32[COST_W-1:0];
            out_ff.bad_setting <= 1'b0;
         end
      end
   end

   assign rsp_valid = vld_ff[OUT_ST];
   assign rsp_data  = out_ff;

endmodule

// ===== src/sebc_sqrt_stage.sv =====
module sebc_sqrt_stage (
   input  logic                        clock,
   input  logic                        en,
   input  logic [sebc_pkg::RAD_W-1:0]  rad_in,
   input  logic [sebc_pkg::REM_W-1:0]  rem_in,
   input  logic [sebc_pkg::ROOT_W-1:0] root_in,
   output logic [sebc_pkg::RAD_W-1:0]  rad_ff,
   output logic [sebc_pkg::REM_W-1:0]  rem_ff,
   output logic [sebc_pkg::ROOT_W-1:0] root_ff
);
   import sebc_pkg::*;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             take;

   always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
      trial  = {root_in, 2'b01};
      take   = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {rad_in[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? rem_sh - trial : rem_sh;
         root_ff <= {root_in[ROOT_W-2:0], take};
      end
   end

endmodule

// ===== src/sebc_div_stage.sv =====
module sebc_div_stage (
   input  logic                       clock,
   input  logic                       en,
   input  logic [sebc_pkg::CH_W-1:0]  divisor,
   input  logic [sebc_pkg::CH_W-1:0]  rem_in,
   input  logic [sebc_pkg::QUO_W-1:0] acc_in,
   output logic [sebc_pkg::CH_W-1:0]  rem_ff,
   output logic [sebc_pkg::QUO_W-1:0] acc_ff
);
   import sebc_pkg::*;

   logic [CH_W:0] rem_sh;
   logic [CH_W:0] diff;
   logic          take;

   always_comb begin
      rem_sh = {rem_in, acc_in[QUO_W-1]};
      take   = rem_sh >= {1'b0, divisor};
      diff   = rem_sh - {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= take ? diff[CH_W-1:0] : rem_sh[CH_W-1:0];
         acc_ff <= {acc_in[QUO_W-2:0], take};
      end
   end

endmodule
